// ----- src/dalp_pkg.sv -----
// shared constants and types for the decimating a-law audio packer
package dalp_pkg;

    localparam int MAX_PACKET_LENGTH_DEF = 4096;

    localparam int SAMPLE_W   = 16;
    localparam int ALAW_W     = 8;
    localparam int PKT_LEN_W  = 13;
    localparam int DEC_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int MAG_W      = 15;
    localparam int SEG_W      = 3;
    localparam int MANT_W     = 4;

    localparam logic [PKT_LEN_W-1:0] PKT_LEN_RESET = 13'd512;
    localparam logic [DEC_W-1:0]     DEC_RESET     = 4'd6;
    localparam logic [MAG_W-1:0]     ALAW_CLIP     = 15'd32635;
    localparam logic [ALAW_W-1:0]    ALAW_XOR      = 8'hD5;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PACKET_LENGTH     = 2'd0,
        CFG_DECIMATION_FACTOR = 2'd1
    } cfg_index_t;

endpackage

// ----- src/dalp_alaw_enc.sv -----
// stereo to mono mix and g.711 a-law encoder
module dalp_alaw_enc (
    input  dalp_pkg::sample_t             left_pcm,
    input  dalp_pkg::sample_t             right_pcm,
    output logic [dalp_pkg::ALAW_W-1:0]   alaw_byte
);
    import dalp_pkg::*;

    logic signed [SAMPLE_W:0] sum;
    logic signed [SAMPLE_W:0] sum_adj;
    logic [SAMPLE_W-1:0]      mono;
    logic                     neg;
    logic [SAMPLE_W:0]        mag_wide;
    logic [SAMPLE_W-1:0]      mag;
    logic [MAG_W-1:0]         mag_clip;
    logic [SEG_W-1:0]         seg;
    logic [3:0]               shift;
    logic [MANT_W-1:0]        mant;

    // odd negative sums are nudged up so the halving truncates toward zero
    assign sum     = {left_pcm[SAMPLE_W-1], left_pcm}
                   + {right_pcm[SAMPLE_W-1], right_pcm};
    assign sum_adj = sum + {{SAMPLE_W{1'b0}}, sum[SAMPLE_W] & sum[0]};
    assign mono    = sum_adj[SAMPLE_W:1];

    assign neg      = mono[SAMPLE_W-1];
    assign mag_wide = neg ? ((SAMPLE_W+1)'(0) - {mono[SAMPLE_W-1], mono})
                          : {mono[SAMPLE_W-1], mono};
    assign mag      = mag_wide[SAMPLE_W-1:0];
    assign mag_clip = (mag > {1'b0, ALAW_CLIP}) ? ALAW_CLIP : mag[MAG_W-1:0];

    // priority encoder over magnitude bits 14 down to 8
    always_comb begin
        if (mag_clip[14]) begin
            seg = 3'd7;
        end else if (mag_clip[13]) begin
            seg = 3'd6;
        end else if (mag_clip[12]) begin
            seg = 3'd5;
        end else if (mag_clip[11]) begin
            seg = 3'd4;
        end else if (mag_clip[10]) begin
            seg = 3'd3;
        end else if (mag_clip[9]) begin
            seg = 3'd2;
        end else if (mag_clip[8]) begin
            seg = 3'd1;
        end else begin
            seg = 3'd0;
        end
    end

    assign shift     = (seg == 3'd0) ? 4'd4 : ({1'b0, seg} + 4'd3);
    assign mant      = MANT_W'(mag_clip >> shift);
    assign alaw_byte = {neg, seg, mant} ^ ALAW_XOR;

endmodule

// ----- src/decimating_alaw_audio_packer.sv -----
// top level of the decimating a-law audio packer
//
// Usage:
//   s_ channel takes one stereo pair of signed 16-bit samples per beat
//   (s_left_pcm, s_right_pcm). One pair in every decimation_factor is
//   kept, starting with the first pair after reset; the rest are dropped
//   and give no output beat. A kept pair is mixed to mono, encoded to a
//   g.711 a-law byte and sent on the m_ channel (m_alaw_byte), with
//   m_last_in_packet high on the byte that closes a packet of packet_length
//   bytes. Registers are written through cfg_wr_en / cfg_index / cfg_wdata
//   (index 0: packet_length, index 1: decimation_factor). The user must
//   write them only while idle; the block itself does not enforce this.
//   A kept pair passes the input register, then the result register,
//   before it is offered on the m_ channel.
//   Throughput: one pair per clock cycle while m_ready stays high, set by
//   the two register stages each passing a beat per cycle.
//   Reset (aresetn low, synchronous) empties both stages, restores the
//   register defaults (512, 6) and clears decimation phase and packet fill.
//   When m_ready is low the result holds, the input register fills, and
//   s_ready then drops until the receiver takes the waiting byte.
module decimating_alaw_audio_packer #(
    parameter int MAX_PACKET_LENGTH = dalp_pkg::MAX_PACKET_LENGTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dalp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dalp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  dalp_pkg::sample_t                   s_left_pcm,
    input  dalp_pkg::sample_t                   s_right_pcm,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dalp_pkg::ALAW_W-1:0]         m_alaw_byte,
    output logic                                m_last_in_packet
);
    import dalp_pkg::*;

    localparam int LEN_W  = $clog2(MAX_PACKET_LENGTH + 1);
    localparam int FILL_W = (MAX_PACKET_LENGTH > 1) ? $clog2(MAX_PACKET_LENGTH) : 1;
    localparam int CMP_W  = ((LEN_W > PKT_LEN_W) ? LEN_W : PKT_LEN_W) + 1;

    logic [PKT_LEN_W-1:0] pkt_len_reg;
    logic [DEC_W-1:0]     dec_factor_reg;
    logic [DEC_W-1:0]     phase_reg;
    logic [DEC_W-1:0]     phase_next;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;

    logic                 in_valid_reg;
    logic                 in_last_reg;
    sample_t              left_reg;
    sample_t              right_reg;

    logic                 out_valid_reg;
    logic                 out_last_reg;
    logic [ALAW_W-1:0]    out_byte_reg;
    logic [ALAW_W-1:0]    enc_byte;

    logic                 s_fire;
    logic                 keep;
    logic                 advance;
    logic [DEC_W:0]       phase_inc;
    logic [CMP_W-1:0]     len_eff;
    logic [CMP_W-1:0]     fill_inc;
    logic                 last_flag;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;
    assign keep    = (phase_reg == '0);

    // phase wraps as soon as phase + 1 reaches or passes the factor
    assign phase_inc  = {1'b0, phase_reg} + (DEC_W+1)'(1);
    assign phase_next = (phase_inc >= {1'b0, dec_factor_reg}) ? '0 : phase_inc[DEC_W-1:0];

    // zero length acts as one, oversize length saturates
    always_comb begin
        len_eff = CMP_W'(pkt_len_reg);
        if (pkt_len_reg == '0) begin
            len_eff = CMP_W'(1);
        end else if (len_eff > CMP_W'(MAX_PACKET_LENGTH)) begin
            len_eff = CMP_W'(MAX_PACKET_LENGTH);
        end
    end

    assign fill_inc  = CMP_W'(fill_reg) + CMP_W'(1);
    assign last_flag = (fill_inc >= len_eff);
    assign fill_next = last_flag ? '0 : FILL_W'(fill_inc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_len_reg    <= PKT_LEN_RESET;
            dec_factor_reg <= DEC_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PACKET_LENGTH:     pkt_len_reg    <= cfg_wdata[PKT_LEN_W-1:0];
                CFG_DECIMATION_FACTOR: dec_factor_reg <= cfg_wdata[DEC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= '0;
            fill_reg     <= '0;
            in_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                phase_reg <= phase_next;
                if (keep) begin
                    fill_reg <= fill_next;
                end
                in_valid_reg <= keep;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && keep) begin
            left_reg    <= s_left_pcm;
            right_reg   <= s_right_pcm;
            in_last_reg <= last_flag;
        end
    end

    dalp_alaw_enc u_enc (
        .left_pcm  (left_reg),
        .right_pcm (right_reg),
        .alaw_byte (enc_byte)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_byte_reg <= enc_byte;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_alaw_byte      = out_byte_reg;
    assign m_last_in_packet = out_last_reg;

`ifndef NO_ASSERTIONS
    // a dropped pair never loads the input register
    a_drop_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !keep) |=> !in_valid_reg)
        else $error("dropped pair reached the input register");

    // packet fill stays below the largest packet
    a_fill_range : assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(fill_reg) < CMP_W'(MAX_PACKET_LENGTH))
        else $error("packet fill out of range");

    // phase never reaches the largest encodable factor
    a_phase_range : assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != '1)
        else $error("decimation phase out of range");

    // a waiting input beat moves on once the result register frees
    a_advance : assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("input beat did not move to the result register");
`endif

endmodule
